// ===== rtl/nra_pkg.sv =====
package nra_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int POS_W      = 32;
    localparam int S_TDATA_W  = 6 * POS_W;
    localparam int M_TDATA_W  = 3 * POS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int GAIN_W   = 32;
    localparam int RADIUS_W = 31;
    localparam int LIMIT_W  = 31;

    localparam int ACC_W  = 48;
    localparam int MID_W  = 62;
    localparam int COMP_W = 47;

    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 64;
    localparam int MUL_DIG_W = 16;
    localparam int MUL_P_W   = 128;

    localparam int DIV_NUM_W = 80;
    localparam int DIV_DEN_W = 48;

    localparam int SQ_RES_W = 48;
    localparam int SQ_RAD_W = 2 * SQ_RES_W;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

    localparam logic [GAIN_W-1:0]   GAIN_RST   = 32'd65536;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd131072;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 31'd327680;

    typedef enum logic [2:0] {
        MS_SQ_AD, MS_T_IP, MS_M_IP, MS_K_M, MS_M_U, MS_LIM, MS_SUM_SQ, MS_SUM_LIM
    } mul_sel_t;

    typedef enum logic [1:0] {
        DS_IP, DS_IS, DS_U, DS_SC
    } div_sel_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_P, DST_IP, DST_IS, DST_M, DST_LIMSQ, DST_N, DST_U, DST_ACC, DST_SC
    } dst_t;

    typedef struct packed {
        logic       load;
        logic       abs_load;
        logic       mul_start;
        logic       mul_clr;
        mul_sel_t   mul_sel;
        logic       div_start;
        div_sel_t   div_sel;
        logic       sqrt_start;
        dst_t       dst;
        logic [1:0] axis;
        logic       out_load;
        logic       out_scaled;
    } nra_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic range_skip;
        logic root_skip;
        logic over_limit;
    } nra_status_t;

endpackage

// ===== rtl/nra_mult.sv =====
module nra_mult import nra_pkg::*; #(
    parameter int A_W   = MUL_A_W,
    parameter int B_W   = MUL_B_W,
    parameter int DIG_W = MUL_DIG_W,
    parameter int P_W   = MUL_P_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic           clr,
    input  logic [A_W-1:0] a_in,
    input  logic [B_W-1:0] b_in,
    output logic [P_W-1:0] prod,
    output logic           done
);

    localparam int NDIG  = B_W / DIG_W;
    localparam int CNT_W = $clog2(NDIG);

    logic [A_W-1:0]       a_reg;
    logic [B_W-1:0]       b_reg;
    logic [P_W-1:0]       p_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [A_W+DIG_W-1:0] partial;
    logic [P_W-1:0]       addend;

    // one digit of b per cycle, accumulated at its weight
    always_comb begin
        partial = a_reg * b_reg[cnt_reg*DIG_W +: DIG_W];
        addend  = P_W'(partial) << (cnt_reg * DIG_W);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(NDIG - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NDIG - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a_in;
            b_reg <= b_in;
            if (clr) begin
                p_reg <= '0;
            end
        end else if (busy_reg) begin
            p_reg <= p_reg + addend;
        end
    end

    assign prod = p_reg;
    assign done = done_reg;

endmodule

// ===== rtl/nra_div.sv =====
module nra_div import nra_pkg::*; #(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        shifted = {rem_reg, num_reg[NUM_W-1]};
        ge      = shifted >= {1'b0, den_reg};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(NUM_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num_in;
            rem_reg <= '0;
            den_reg <= den_in;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], ge};
        end
    end

    assign quo  = num_reg;
    assign done = done_reg;

endmodule

// ===== rtl/nra_sqrt.sv =====
module nra_sqrt import nra_pkg::*; #(
    parameter int RES_W = SQ_RES_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [2*RES_W-1:0] rad_in,
    output logic [RES_W-1:0]   root,
    output logic               done
);

    localparam int RAD_W = 2 * RES_W;
    localparam int REM_W = RES_W + 2;
    localparam int CNT_W = $clog2(RES_W);

    logic [RAD_W-1:0] rad_reg;
    logic [RES_W-1:0] root_reg;
    logic [REM_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] rem_sub;
    logic             ge;

    // digit-by-digit root, two radicand bits per cycle
    always_comb begin
        rem_sh  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = (REM_W + 2)'({root_reg, 2'b01});
        ge      = rem_sh >= trial;
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(RES_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RES_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad_in;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[RES_W-2:0], ge};
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ===== rtl/nra_dpath.sv =====
module nra_dpath import nra_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  nra_cmd_t              cmd,
    output nra_status_t           status,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser
);

    localparam int D_W   = POS_W + 1;
    localparam int IP_W  = 2 * FRAC_BITS + 1;
    localparam int U_W   = FRAC_BITS + 1;
    localparam int LIM_W = LIMIT_W - 1;
    localparam int C_W   = ACC_W + 1;

    localparam logic [MID_W-1:0]  MID_CAP  = {MID_W{1'b1}};
    localparam logic [COMP_W-1:0] COMP_CAP = {COMP_W{1'b1}};
    localparam logic [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

    logic [GAIN_W-1:0]   gain_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LIM_W-1:0]    lim;

    logic signed [D_W-1:0]   d_reg   [0:2];
    logic        [D_W-1:0]   ad_reg  [0:2];
    logic        [D_W-1:0]   ad_next [0:2];
    logic signed [ACC_W-1:0] sum_reg [0:2];
    logic        [ACC_W-1:0] sum_mag [0:2];
    logic        [POS_W-1:0] sc_reg  [0:2];
    logic        [POS_W-1:0] force_reg [0:2];
    logic                    limited_reg;

    logic [POS_W-1:0]   p_reg;
    logic [IP_W-1:0]    ip_reg;
    logic [IP_W-1:0]    is_reg;
    logic [MID_W-1:0]   m_reg;
    logic [U_W-1:0]     u_reg;
    logic [2*LIM_W-1:0] limsq_reg;
    logic [SQ_RES_W-1:0] n_reg;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic                 mul_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    logic                 div_done;
    logic [SQ_RES_W-1:0]  sq_root;
    logic                 sq_done;

    logic [MUL_P_W-1:0]    p_shift;
    logic [MID_W-1:0]      mid_sat;
    logic [COMP_W-1:0]     comp_sat;
    logic signed [C_W-1:0] c_sgn;
    logic signed [C_W-1:0] acc_sum;
    logic [ACC_W-1:0]      acc_new;
    logic [POS_W-1:0]      q_lo;
    logic [POS_W-1:0]      sc_val;
    logic                  range_skip;

    assign lim = limit_reg[LIMIT_W-1:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RST;
            radius_reg <= RADIUS_RST;
            limit_reg  <= LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GAIN:   gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_RADIUS: radius_reg <= cfg_wdata[RADIUS_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        range_skip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            ad_next[i] = d_reg[i][D_W-1] ? D_W'(-d_reg[i]) : D_W'(d_reg[i]);
            if (ad_next[i] >= D_W'(radius_reg)) begin
                range_skip = 1'b1;
            end
            sum_mag[i] = sum_reg[i][ACC_W-1] ? ACC_W'(-sum_reg[i]) : ACC_W'(sum_reg[i]);
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MS_SQ_AD: begin
                mul_a = MUL_A_W'(ad_reg[cmd.axis]);
                mul_b = MUL_B_W'(ad_reg[cmd.axis]);
            end
            MS_T_IP: begin
                mul_a = MUL_A_W'(IP_W'(ip_reg - is_reg));
                mul_b = MUL_B_W'(ip_reg);
            end
            MS_M_IP: begin
                mul_a = MUL_A_W'(m_reg);
                mul_b = MUL_B_W'(ip_reg);
            end
            MS_K_M: begin
                mul_a = MUL_A_W'(gain_reg);
                mul_b = MUL_B_W'(m_reg);
            end
            MS_M_U: begin
                mul_a = MUL_A_W'(m_reg);
                mul_b = MUL_B_W'(u_reg);
            end
            MS_LIM: begin
                mul_a = MUL_A_W'(lim);
                mul_b = MUL_B_W'(lim);
            end
            MS_SUM_SQ: begin
                mul_a = MUL_A_W'(sum_mag[cmd.axis]);
                mul_b = MUL_B_W'(sum_mag[cmd.axis]);
            end
            MS_SUM_LIM: begin
                mul_a = MUL_A_W'(sum_mag[cmd.axis]);
                mul_b = MUL_B_W'(lim);
            end
            default: ;
        endcase
    end

    always_comb begin
        div_num = '0;
        div_den = '0;
        case (cmd.div_sel)
            DS_IP: begin
                div_num = DIV_NUM_W'(1) << (2 * FRAC_BITS);
                div_den = DIV_DEN_W'(p_reg);
            end
            DS_IS: begin
                div_num = DIV_NUM_W'(1) << (2 * FRAC_BITS);
                div_den = DIV_DEN_W'(radius_reg);
            end
            DS_U: begin
                div_num = DIV_NUM_W'(ad_reg[cmd.axis]) << FRAC_BITS;
                div_den = DIV_DEN_W'(p_reg);
            end
            DS_SC: begin
                div_num = mul_p[DIV_NUM_W-1:0];
                div_den = DIV_DEN_W'(n_reg);
            end
            default: ;
        endcase
    end

    nra_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .clr     (cmd.mul_clr),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .prod    (mul_p),
        .done    (mul_done)
    );

    nra_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num_in  (div_num),
        .den_in  (div_den),
        .quo     (div_quo),
        .done    (div_done)
    );

    nra_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .rad_in  (mul_p[SQ_RAD_W-1:0]),
        .root    (sq_root),
        .done    (sq_done)
    );

    // fixed point rescale with saturation, then signed saturating accumulate, and the signed rescaled quotient
    always_comb begin
        p_shift  = mul_p >> FRAC_BITS;
        mid_sat  = (p_shift > MUL_P_W'(MID_CAP)) ? MID_CAP : p_shift[MID_W-1:0];
        comp_sat = (p_shift > MUL_P_W'(COMP_CAP)) ? COMP_CAP : p_shift[COMP_W-1:0];
        c_sgn    = d_reg[cmd.axis][D_W-1] ? -$signed(C_W'(comp_sat))
                                          : $signed(C_W'(comp_sat));
        acc_sum  = C_W'(sum_reg[cmd.axis]) + c_sgn;
        if (acc_sum[C_W-1] != acc_sum[C_W-2]) begin
            acc_new = acc_sum[C_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_new = acc_sum[ACC_W-1:0];
        end
        q_lo   = div_quo[POS_W-1:0];
        sc_val = sum_reg[cmd.axis][ACC_W-1] ? POS_W'(-q_lo) : q_lo;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= $signed({s_tdata[i*POS_W+POS_W-1], s_tdata[i*POS_W +: POS_W]})
                          - $signed({s_tdata[(i+3)*POS_W+POS_W-1],
                                     s_tdata[(i+3)*POS_W +: POS_W]});
            end
        end
        if (cmd.abs_load) begin
            for (int i = 0; i < 3; i++) begin
                ad_reg[i] <= ad_next[i];
            end
        end
        case (cmd.dst)
            DST_P:     p_reg     <= sq_root[POS_W-1:0];
            DST_IP:    ip_reg    <= div_quo[IP_W-1:0];
            DST_IS:    is_reg    <= div_quo[IP_W-1:0];
            DST_M:     m_reg     <= mid_sat;
            DST_LIMSQ: limsq_reg <= mul_p[2*LIM_W-1:0];
            DST_N:     n_reg     <= sq_root;
            DST_U:     u_reg     <= div_quo[U_W-1:0];
            DST_SC:    sc_reg[cmd.axis] <= sc_val;
            default: ;
        endcase
        if (cmd.out_load) begin
            for (int i = 0; i < 3; i++) begin
                force_reg[i] <= cmd.out_scaled ? sc_reg[i] : sum_reg[i][POS_W-1:0];
            end
            limited_reg <= cmd.out_scaled;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (cmd.out_load) begin
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (cmd.dst == DST_ACC) begin
            sum_reg[cmd.axis] <= acc_new;
        end
    end

    always_comb begin
        status.mul_done   = mul_done;
        status.div_done   = div_done;
        status.sqrt_done  = sq_done;
        status.range_skip = range_skip;
        status.root_skip  = (sq_root == '0) || (sq_root >= SQ_RES_W'(radius_reg));
        status.over_limit = mul_p > MUL_P_W'(limsq_reg);
    end

    assign m_tdata = {force_reg[2], force_reg[1], force_reg[0]};
    assign m_tuser = limited_reg;

endmodule

// ===== rtl/nra_ctrl.sv =====
module nra_ctrl import nra_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tlast,
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  nra_status_t status,
    output nra_cmd_t    cmd
);

    localparam logic [1:0] AXIS_FIRST = 2'd0;
    localparam logic [1:0] AXIS_LAST  = 2'd2;
    localparam logic [1:0] AXIS_BAD   = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ABS, ST_SQ, ST_ROOT, ST_DIV_IP, ST_DIV_IS, ST_MUL_T, ST_MUL_C2,
        ST_MUL_K, ST_DIV_U, ST_MUL_C, ST_FIN, ST_LIMSQ, ST_NSQ, ST_NROOT, ST_SC_MUL,
        ST_SC_DIV, ST_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] axis_reg;
    logic       issued_reg;
    logic       last_reg;
    logic       limited_reg;
    logic       m_tvalid_reg;
    logic       op_done;

    always_comb begin
        case (state_reg)
            ST_SQ, ST_MUL_T, ST_MUL_C2, ST_MUL_K, ST_MUL_C, ST_LIMSQ, ST_NSQ, ST_SC_MUL:
                op_done = status.mul_done;
            ST_DIV_IP, ST_DIV_IS, ST_DIV_U, ST_SC_DIV:
                op_done = status.div_done;
            ST_ROOT, ST_NROOT:
                op_done = status.sqrt_done;
            default:
                op_done = 1'b0;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.axis    = axis_reg;
        cmd.mul_clr = 1'b1;
        case (state_reg)
            ST_IDLE: cmd.load = s_tvalid;
            ST_ABS:  cmd.abs_load = 1'b1;
            ST_SQ: begin
                cmd.mul_start = !issued_reg;
                cmd.mul_clr   = axis_reg == AXIS_FIRST;
                cmd.mul_sel   = MS_SQ_AD;
            end
            ST_ROOT: begin
                cmd.sqrt_start = !issued_reg;
                cmd.dst        = op_done ? DST_P : DST_NONE;
            end
            ST_DIV_IP: begin
                cmd.div_start = !issued_reg;
                cmd.div_sel   = DS_IP;
                cmd.dst       = op_done ? DST_IP : DST_NONE;
            end
            ST_DIV_IS: begin
                cmd.div_start = !issued_reg;
                cmd.div_sel   = DS_IS;
                cmd.dst       = op_done ? DST_IS : DST_NONE;
            end
            ST_MUL_T: begin
                cmd.mul_start = !issued_reg;
                cmd.mul_sel   = MS_T_IP;
                cmd.dst       = op_done ? DST_M : DST_NONE;
            end
            ST_MUL_C2: begin
                cmd.mul_start = !issued_reg;
                cmd.mul_sel   = MS_M_IP;
                cmd.dst       = op_done ? DST_M : DST_NONE;
            end
            ST_MUL_K: begin
                cmd.mul_start = !issued_reg;
                cmd.mul_sel   = MS_K_M;
                cmd.dst       = op_done ? DST_M : DST_NONE;
            end
            ST_DIV_U: begin
                cmd.div_start = !issued_reg;
                cmd.div_sel   = DS_U;
                cmd.dst       = op_done ? DST_U : DST_NONE;
            end
            ST_MUL_C: begin
                cmd.mul_start = !issued_reg;
                cmd.mul_sel   = MS_M_U;
                cmd.dst       = op_done ? DST_ACC : DST_NONE;
            end
            ST_LIMSQ: begin
                cmd.mul_start = !issued_reg;
                cmd.mul_sel   = MS_LIM;
                cmd.dst       = op_done ? DST_LIMSQ : DST_NONE;
            end
            ST_NSQ: begin
                cmd.mul_start = !issued_reg;
                cmd.mul_clr   = axis_reg == AXIS_FIRST;
                cmd.mul_sel   = MS_SUM_SQ;
            end
            ST_NROOT: begin
                cmd.sqrt_start = !issued_reg;
                cmd.dst        = op_done ? DST_N : DST_NONE;
            end
            ST_SC_MUL: begin
                cmd.mul_start = !issued_reg;
                cmd.mul_sel   = MS_SUM_LIM;
            end
            ST_SC_DIV: begin
                cmd.div_start = !issued_reg;
                cmd.div_sel   = DS_SC;
                cmd.dst       = op_done ? DST_SC : DST_NONE;
            end
            ST_OUT: begin
                cmd.out_load   = !m_tvalid_reg || m_tready;
                cmd.out_scaled = limited_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            axis_reg     <= AXIS_FIRST;
            issued_reg   <= 1'b0;
            last_reg     <= 1'b0;
            limited_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_OUT) && cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (op_done) begin
                issued_reg <= 1'b0;
            end else if (cmd.mul_start || cmd.div_start || cmd.sqrt_start) begin
                issued_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        last_reg  <= s_tlast;
                        state_reg <= s_tuser ? ST_ABS : ST_FIN;
                    end
                end
                ST_ABS: begin
                    axis_reg  <= AXIS_FIRST;
                    state_reg <= status.range_skip ? ST_FIN : ST_SQ;
                end
                ST_SQ: begin
                    if (op_done) begin
                        if (axis_reg == AXIS_LAST) begin
                            axis_reg  <= AXIS_FIRST;
                            state_reg <= ST_ROOT;
                        end else begin
                            axis_reg <= axis_reg + 1'b1;
                        end
                    end
                end
                ST_ROOT: begin
                    if (op_done) begin
                        state_reg <= status.root_skip ? ST_FIN : ST_DIV_IP;
                    end
                end
                ST_DIV_IP: if (op_done) state_reg <= ST_DIV_IS;
                ST_DIV_IS: if (op_done) state_reg <= ST_MUL_T;
                ST_MUL_T:  if (op_done) state_reg <= ST_MUL_C2;
                ST_MUL_C2: if (op_done) state_reg <= ST_MUL_K;
                ST_MUL_K: begin
                    if (op_done) begin
                        axis_reg  <= AXIS_FIRST;
                        state_reg <= ST_DIV_U;
                    end
                end
                ST_DIV_U: if (op_done) state_reg <= ST_MUL_C;
                ST_MUL_C: begin
                    if (op_done) begin
                        if (axis_reg == AXIS_LAST) begin
                            axis_reg  <= AXIS_FIRST;
                            state_reg <= ST_FIN;
                        end else begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= ST_DIV_U;
                        end
                    end
                end
                ST_FIN: begin
                    axis_reg  <= AXIS_FIRST;
                    state_reg <= last_reg ? ST_LIMSQ : ST_IDLE;
                end
                ST_LIMSQ: if (op_done) state_reg <= ST_NSQ;
                ST_NSQ: begin
                    if (op_done) begin
                        if (axis_reg == AXIS_LAST) begin
                            axis_reg    <= AXIS_FIRST;
                            limited_reg <= status.over_limit;
                            state_reg   <= status.over_limit ? ST_NROOT : ST_OUT;
                        end else begin
                            axis_reg <= axis_reg + 1'b1;
                        end
                    end
                end
                ST_NROOT: if (op_done) state_reg <= ST_SC_MUL;
                ST_SC_MUL: if (op_done) state_reg <= ST_SC_DIV;
                ST_SC_DIV: begin
                    if (op_done) begin
                        if (axis_reg == AXIS_LAST) begin
                            axis_reg  <= AXIS_FIRST;
                            state_reg <= ST_OUT;
                        end else begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= ST_SC_MUL;
                        end
                    end
                end
                ST_OUT: begin
                    if (cmd.out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;

    a_accept_no_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !issued_reg)
        else $error("request accepted with an arithmetic op in flight");

    a_one_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.mul_start, cmd.div_start, cmd.sqrt_start}))
        else $error("more than one unit started");

    a_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.mul_done || status.div_done || status.sqrt_done) |-> issued_reg)
        else $error("unit finished without a pending op");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        axis_reg != AXIS_BAD)
        else $error("axis index out of range");

endmodule

// ===== rtl/neighbor_repulsion_accumulator_top.sv =====
// channel   direction  handshake                  payload
// s_        in         s_tvalid/s_tready, s_tlast  s_tdata positions, s_tuser presence flag
// m_        out        m_tvalid/m_tready           m_tdata force, m_tuser limited flag
// cfg_      in         cfg_we                      cfg_index, cfg_wdata
//
// an empty request goes straight to the finish state; a neighbor inside the radius
// runs five passes of the radix-2 divider, one square root and nine multiplies; a
// neighbor out of range stops after the range check
// a last request adds the norm check, and a rescale when the vector is over the limit
// reset is synchronous, active low, and clears control, accumulators and configuration registers
// the result sits in an output register; a new request is taken while it waits,
// and only the next result stalls on m_tready
module neighbor_repulsion_accumulator_top import nra_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // own_x, own_y, own_z, nbr_x, nbr_y, nbr_z
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // nbr_present
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // force_x, force_y, force_z
    output logic [M_TDATA_W-1:0]  m_tdata,
    // was_limited
    output logic                  m_tuser
);

    nra_cmd_t    cmd;
    nra_status_t status;

    nra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nra_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== tb/neighbor_repulsion_accumulator_checker.sv =====
module neighbor_repulsion_accumulator_checker import nra_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tuser,
    output int                    fail_count,
    output int                    pending_forces,
    output int                    forces_seen,
    output int                    limited_seen
);

    localparam int F = FRAC_BITS_DEF;
    localparam logic [127:0] MID_CAP  = 128'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [127:0] COMP_CAP = 128'h7FFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = -64'sh8000_0000_0000;

    typedef struct {
        logic [31:0] fx, fy, fz;
        logic        limited;
    } force_t;

    force_t expected_forces[$];
    logic [31:0] gain;
    logic [30:0] radius, limit;
    logic signed [63:0] acc[3];

    function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b,
                                                  logic [127:0] cap);
        logic [127:0] prod;
        prod = ({64'd0, a} * {64'd0, b}) >> F;
        return (prod > cap) ? cap[63:0] : prod[63:0];
    endfunction

    function automatic logic [63:0] root128(logic [127:0] x);
        logic [63:0] r;
        logic [127:0] c;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            c = {64'd0, r | (64'd1 << i)};
            if (c * c <= x) r = c[63:0];
        end
        return r;
    endfunction

    task automatic add_neighbor(logic [S_TDATA_W-1:0] d);
        logic signed [63:0] df[3];
        logic [63:0] ad[3];
        logic [127:0] sq;
        logic [63:0] p, ip, is, m, u, c;
        for (int i = 0; i < 3; i++) begin
            df[i] = 64'(signed'(d[32*i +: 32])) - 64'(signed'(d[32*(i+3) +: 32]));
            ad[i] = df[i] < 0 ? 64'(-df[i]) : 64'(df[i]);
            if (ad[i] >= {33'd0, radius}) return;
        end
        sq = 0;
        for (int i = 0; i < 3; i++) sq += {64'd0, ad[i]} * {64'd0, ad[i]};
        p = root128(sq);
        if (p == 0 || p >= {33'd0, radius}) return;
        ip = (64'd1 << (2 * F)) / p;
        is = (64'd1 << (2 * F)) / {33'd0, radius};
        m = mul_shift_sat(ip - is, ip, MID_CAP);
        m = mul_shift_sat(m, ip, MID_CAP);
        m = mul_shift_sat({32'd0, gain}, m, MID_CAP);
        for (int i = 0; i < 3; i++) begin
            u = (ad[i] << F) / p;
            c = mul_shift_sat(m, u, COMP_CAP);
            acc[i] = acc[i] + (df[i] < 0 ? -signed'(c) : signed'(c));
            if (acc[i] > ACC_MAX) acc[i] = ACC_MAX;
            if (acc[i] < ACC_MIN) acc[i] = ACC_MIN;
        end
    endtask

    task automatic close_set();
        logic [127:0] nsq, lim, n, mag;
        logic signed [63:0] v[3];
        force_t f;
        lim = {97'd0, limit >> 1};
        nsq = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = acc[i];
            mag = {64'd0, acc[i] < 0 ? 64'(-acc[i]) : 64'(acc[i])};
            nsq += mag * mag;
        end
        f.limited = nsq > lim * lim;
        if (f.limited) begin
            n = {64'd0, root128(nsq)};
            for (int i = 0; i < 3; i++) begin
                mag = {64'd0, acc[i] < 0 ? 64'(-acc[i]) : 64'(acc[i])};
                mag = (mag * lim) / n;
                v[i] = acc[i] < 0 ? -signed'(mag[63:0]) : signed'(mag[63:0]);
            end
        end
        f.fx = v[0][31:0];
        f.fy = v[1][31:0];
        f.fz = v[2][31:0];
        expected_forces.push_back(f);
        for (int i = 0; i < 3; i++) acc[i] = 0;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        force_t f;
        if (!aresetn) begin
            gain <= GAIN_RST;
            radius <= RADIUS_RST;
            limit <= LIMIT_RST;
            for (int i = 0; i < 3; i++) acc[i] = 0;
            expected_forces.delete();
            fail_count = 0;
            forces_seen = 0;
            limited_seen = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GAIN: begin
                        gain <= cfg_wdata;
                    end
                    REG_RADIUS: begin
                        radius <= cfg_wdata[30:0];
                    end
                    REG_LIMIT: begin
                        limit <= cfg_wdata[30:0];
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser) add_neighbor(s_tdata);
                if (s_tlast) close_set();
            end
            if (m_tvalid && m_tready) begin
                if (expected_forces.size() == 0) begin
                    report("unexpected force", m_tdata[31:0], 32'd0);
                end else begin
                    f = expected_forces.pop_front();
                    forces_seen++;
                    if (f.limited) limited_seen++;
                    if (m_tdata[31:0] !== f.fx) report("force_x", m_tdata[31:0], f.fx);
                    if (m_tdata[63:32] !== f.fy) report("force_y", m_tdata[63:32], f.fy);
                    if (m_tdata[95:64] !== f.fz) report("force_z", m_tdata[95:64], f.fz);
                    if (m_tuser !== f.limited) begin
                        report("was_limited", {31'd0, m_tuser}, {31'd0, f.limited});
                    end
                end
            end
        end
        pending_forces = expected_forces.size();
    end

endmodule

// ===== tb/neighbor_repulsion_accumulator_top_test.sv =====
module neighbor_repulsion_accumulator_top_test;
    import nra_pkg::*;

    localparam longint CYCLE_LIMIT = 3_000_000;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_GAIN;
    logic [CFG_DATA_W-1:0] cfg_wdata = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = 0;
    logic                  s_tuser = 0;
    logic                  s_tlast = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    int fail_count, pending_forces, forces_seen, limited_seen;
    int send_idle_pct = 0, recv_idle_pct = 0;
    int requests_sent = 0;
    longint cycles = 0;
    logic [31:0] own[3];

    always #5 aclk = ~aclk;

    neighbor_repulsion_accumulator_top u_top (.*);

    neighbor_repulsion_accumulator_checker u_check (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send(logic [31:0] ox, oy, oz, nx, ny, nz, logic present, logic last);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tdata <= {nz, ny, nx, oz, oy, ox};
        s_tuser <= present;
        s_tlast <= last;
        s_tvalid <= 1;
        while (!s_tready) @(negedge aclk);
        @(negedge aclk);
        s_tvalid <= 0;
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_forces != 0) @(negedge aclk);
        repeat (800) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 0;
        @(negedge aclk);
    endtask

    // neighbor offset drawn within span of the base on each axis
    function automatic logic [31:0] near(logic [31:0] base, int span);
        return base + 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic random_set(int span);
        int n;
        n = $urandom_range(5);
        for (int i = 0; i < 3; i++) own[i] = $urandom;
        for (int i = 0; i <= n; i++) begin
            if ($urandom_range(9) == 0) begin
                send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(1), i == n);
            end else begin
                send(own[0], own[1], own[2], near(own[0], span), near(own[1], span),
                     near(own[2], span), $urandom_range(9) != 0, i == n);
            end
        end
    endtask

    task automatic random_phase(int count, int span);
        int start;
        start = requests_sent;
        while (requests_sent - start < count) random_set(span);
        wait_drained();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: reset settings
        send(0, 0, 0, 0, 0, 0, 0, 1);
        send(0, 0, 0, 0, 0, 0, 1, 1);
        send(32'h10000, 0, 0, 0, 0, 0, 1, 0);
        send(0, 32'h8000, 0, 0, 0, 32'h8000, 1, 0);
        send(5, 7, 9, 5, 7, 10, 1, 0);
        send(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 1, 1);
        send(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFF0,
             32'h8000_0005, 32'hFFFF_FFF0, 1, 0);
        send(0, 0, 0, 32'h1000, 32'hFFFF_F000, 32'h800, 1, 1);
        send(0, 0, 0, 0, 0, 0, 1, 0);
        send(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0, 0, 1, 1);
        wait_drained();

        // extremes: huge gain, radius and limit to saturate, then zero limit, zero gain and radius of one and zero
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_RADIUS, 32'h7FFF_FFFF);
        write_reg(REG_LIMIT, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++) send(0, 0, 0, 1, 1, 0, 1, 0);
        send(0, 0, 0, 32'hFFFF_FFFF, 0, 0, 1, 1);
        wait_drained();
        write_reg(REG_LIMIT, 0);
        send(0, 0, 0, 32'h100, 32'h200, 32'h300, 1, 1);
        send(0, 0, 0, 0, 0, 0, 0, 1);
        wait_drained();
        write_reg(REG_GAIN, 0);
        write_reg(REG_RADIUS, 1);
        send(0, 0, 0, 1, 0, 0, 1, 1);
        wait_drained();
        write_reg(REG_RADIUS, 0);
        send(0, 0, 0, 1, 0, 0, 1, 1);
        wait_drained();

        send_idle_pct = 19;
        recv_idle_pct = 63;
        write_reg(REG_GAIN, 32'h10000);
        write_reg(REG_RADIUS, 32'h20000);
        write_reg(REG_LIMIT, 32'h50000);
        random_phase(220, 32'h28000);

        send_idle_pct = 63;
        recv_idle_pct = 19;
        write_reg(REG_GAIN, $urandom);
        write_reg(REG_RADIUS, 32'h7FFF_FFFF);
        write_reg(REG_LIMIT, $urandom_range(32'h7FFF_FFFF));
        random_phase(200, 32'h4_0000);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_GAIN, 32'h8000);
        write_reg(REG_RADIUS, 32'h1000);
        write_reg(REG_LIMIT, 32'h800);
        random_phase(200, 32'h1000);

        $display("%0d requests sent, %0d forces checked, %0d of them limited",
                 requests_sent, forces_seen, limited_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
